// ----- sv/lbfs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbfs_pkg - shared types and constants for the line byte/field selector
// Command format between the front and back ends, configuration layout,
// register indexes and the back end state encoding.
// ---------------------------------------------------------------------------
package lbfs_pkg;

    // Line length default (a line chunk closes once LINE_LEN - 1 bytes have been taken)
    localparam int LINE_LEN_DEF = 64;

    // First-field store: index width covers the largest line length
    localparam int IDX_W         = 6;
    localparam int STORE_ENTRIES = 2 ** IDX_W;

    // Selection mask and field counter
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int FNUM_W     = 7;
    localparam logic [FNUM_W-1:0] FNUM_MAX = 7'd127;

    // Character codes
    localparam logic [7:0] NL_BYTE  = 8'h0A;
    localparam logic [7:0] TAB_BYTE = 8'h09;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    // Command queue depth between front and back ends
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FIELD_MODE  = 2'd0,
        CFG_DELIMITER   = 2'd1,
        CFG_SUPPRESS    = 2'd2,
        CFG_SELECT_MASK = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              field_mode;
        logic [7:0]        delimiter;
        logic              suppress_plain;
        logic [MASK_W-1:0] select_mask;
    } cfg_t;

    // Work for one accepted byte, carried out in order:
    // store write, drain of the first field, single byte, newline
    typedef struct packed {
        logic [7:0]       data;
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic             drain;
        logic [IDX_W-1:0] cnt;
        logic             emit;
        logic             nl;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE,
        BK_DRAIN,
        BK_EMIT,
        BK_NL
    } bk_state_t;

    // Position or field k (1-based) selected by the mask; k beyond the mask is never selected
    function automatic logic picked(input logic [MASK_W-1:0] mask, input logic [FNUM_W-1:0] k);
        logic [FNUM_W-1:0] km1;
        km1 = k - 1'b1;
        return (k != '0) && (k <= FNUM_W'(MASK_W)) && mask[km1[MASK_IDX_W-1:0]];
    endfunction

endpackage

// ----- sv/lbfs_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbfs_front - byte classifier and line state
// Takes one byte per transaction, tracks the open line (length, field number,
// first-field fill, flags) and issues at most one command describing its output.
// ---------------------------------------------------------------------------
module lbfs_front #(
    parameter int LINE_LEN = lbfs_pkg::LINE_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lbfs_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            final_req,
    input  logic            q_full,
    output logic            cmd_push,
    output lbfs_pkg::cmd_t  cmd
);
    import lbfs_pkg::*;

    // A line closes once this many bytes have been taken
    localparam logic [IDX_W-1:0] CLOSE_AT = IDX_W'(LINE_LEN - 1);

    logic [IDX_W-1:0]  chunk_reg, chunk_next;
    logic [IDX_W-1:0]  stored_reg, stored_next;
    logic [FNUM_W-1:0] fnum_reg, fnum_next;
    logic              seen_reg, seen_next;
    logic              printed_reg, printed_next;
    logic              past_zero_reg, past_zero_next;

    logic             accept;
    logic [IDX_W-1:0] chunk_inc;
    logic             is_nl;
    logic             text;
    logic             take;
    logic             close;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Classify the byte and work out the line state after it
    always_comb
    begin
        chunk_next     = chunk_reg;
        stored_next    = stored_reg;
        fnum_next      = fnum_reg;
        seen_next      = seen_reg;
        printed_next   = printed_reg;
        past_zero_next = past_zero_reg;
        cmd            = '0;
        cmd.data       = in_byte;

        chunk_inc = (chunk_reg < CLOSE_AT) ? chunk_reg + 1'b1 : chunk_reg;
        is_nl     = (in_byte == NL_BYTE);
        text      = !is_nl && !past_zero_reg;
        take      = text && (in_byte != NUL_BYTE);

        if (text && (in_byte == NUL_BYTE))
        begin
            past_zero_next = 1'b1;
        end

        if (take)
        begin
            if (!cfg.field_mode)
            begin
                // byte positions
                cmd.emit = picked(cfg.select_mask, FNUM_W'(chunk_inc));
            end
            else if (in_byte == cfg.delimiter)
            begin
                if (!seen_reg)
                begin
                    // first delimiter: release the buffered first field
                    seen_next = 1'b1;
                    if (cfg.select_mask[0])
                    begin
                        cmd.drain    = (stored_reg != '0);
                        cmd.cnt      = stored_reg;
                        printed_next = 1'b1;
                    end
                    fnum_next = FNUM_W'(2);
                end
                else if (fnum_reg < FNUM_MAX)
                begin
                    fnum_next = fnum_reg + 1'b1;
                end
                if (picked(cfg.select_mask, fnum_next))
                begin
                    cmd.emit     = printed_next;
                    printed_next = 1'b1;
                end
            end
            else if (!seen_reg)
            begin
                // buffer the first field
                if (stored_reg < CLOSE_AT)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_idx  = stored_reg;
                    stored_next = stored_reg + 1'b1;
                end
            end
            else
            begin
                cmd.emit = picked(cfg.select_mask, fnum_reg);
            end
        end

        close = is_nl || final_req || (chunk_inc >= CLOSE_AT);

        // Line close and return to fresh-line values
        if (close)
        begin
            if (!cfg.field_mode || seen_next)
            begin
                cmd.nl = 1'b1;
            end
            else if (cfg.delimiter == NUL_BYTE)
            begin
                if (cfg.select_mask[0])
                begin
                    cmd.drain = (stored_next != '0);
                    cmd.cnt   = stored_next;
                end
                cmd.nl = 1'b1;
            end
            else if (!cfg.suppress_plain)
            begin
                cmd.drain = (stored_next != '0);
                cmd.cnt   = stored_next;
                cmd.nl    = 1'b1;
            end
            chunk_next     = '0;
            stored_next    = '0;
            fnum_next      = FNUM_W'(1);
            seen_next      = 1'b0;
            printed_next   = 1'b0;
            past_zero_next = 1'b0;
        end
        else
        begin
            chunk_next = chunk_inc;
        end
    end

    assign cmd_push = accept && (cmd.wr || cmd.drain || cmd.emit || cmd.nl);

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg     <= '0;
            stored_reg    <= '0;
            fnum_reg      <= FNUM_W'(1);
            seen_reg      <= 1'b0;
            printed_reg   <= 1'b0;
            past_zero_reg <= 1'b0;
        end
        else if (accept)
        begin
            chunk_reg     <= chunk_next;
            stored_reg    <= stored_next;
            fnum_reg      <= fnum_next;
            seen_reg      <= seen_next;
            printed_reg   <= printed_next;
            past_zero_reg <= past_zero_next;
        end
    end

endmodule

// ----- sv/lbfs_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbfs_queue - command queue between front and back ends
// Small circular buffer of commands; lets either side stall on its own.
// ---------------------------------------------------------------------------
module lbfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lbfs_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output lbfs_pkg::cmd_t  head
);
    import lbfs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entries_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            // both or neither: fill level unchanged
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("command popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ----- sv/lbfs_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbfs_back - command sequencer and output stage
// Holds the first-field store, carries out each command one output byte per
// cycle while out_ready lets the output register load, and drives the
// registered output channel.
module lbfs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  lbfs_pkg::cmd_t  q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_run
);
    import lbfs_pkg::*;

    bk_state_t        state_reg, state_next;
    cmd_t             work_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data_reg;
    logic [7:0]       store_mem [STORE_ENTRIES];

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       out_load;
    logic       out_push;
    logic [7:0] push_byte;
    logic       push_last;
    logic       last_drain;

    assign out_load   = !out_valid_reg || out_ready;
    assign last_drain = (idx_reg == work_reg.cnt - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    priority if (q_head.drain) state_next = BK_PRE;
                    else if (q_head.emit)      state_next = BK_EMIT;
                    else if (q_head.nl)        state_next = BK_NL;
                    else                       state_next = BK_IDLE;
                end
            end
            BK_PRE:
            begin
                state_next = BK_DRAIN;
            end
            BK_DRAIN:
            begin
                if (out_load && last_drain)
                begin
                    priority if (work_reg.emit) state_next = BK_EMIT;
                    else if (work_reg.nl)       state_next = BK_NL;
                    else                        state_next = BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (out_load)
                begin
                    state_next = work_reg.nl ? BK_NL : BK_IDLE;
                end
            end
            BK_NL:
            begin
                if (out_load)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop     = 1'b0;
        out_push  = 1'b0;
        push_byte = work_reg.data;
        push_last = 1'b0;
        idx_next  = idx_reg;
        rd_addr   = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                idx_next = '0;
            end
            BK_PRE:
            begin
                rd_addr = idx_reg;
            end
            BK_DRAIN:
            begin
                out_push  = out_load;
                push_byte = rd_data_reg;
                push_last = last_drain && !work_reg.emit && !work_reg.nl;
                if (out_load)
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            BK_EMIT:
            begin
                out_push  = out_load;
                push_byte = work_reg.data;
                push_last = !work_reg.nl;
            end
            BK_NL:
            begin
                out_push  = out_load;
                push_byte = NL_BYTE;
                push_last = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Current command
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_head;
        end
    end

    // First-field store: written as commands leave the queue, registered read
    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.wr)
        begin
            store_mem[q_head.wr_idx] <= q_head.data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= push_byte;
            out_last_reg  <= push_last;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> ((work_reg.cnt != '0) && (idx_reg < work_reg.cnt)))
        else $error("drain index outside the buffered first field");

    a_pre_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_PRE) |=> (state_reg == BK_DRAIN))
        else $error("store read not followed by drain");

    a_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != BK_IDLE) && (state_reg != BK_PRE) && (state_next == BK_IDLE))
            |-> (out_push && push_last))
        else $error("command finished without marking its last byte");
`endif

endmodule

// ----- sv/line_byte_field_selector.sv -----
`timescale 1ns / 1ps
// Path: a byte that emits a single byte goes through the command queue, the back end's
//   command register and the output register; a first-field drain adds a store read (BK_PRE).
// Flow: the back end takes one command at a time in BK_IDLE and finishes its output bytes,
//   stalling while out_ready is low, before taking the next; the front takes a byte
//   whenever the 2-entry command queue has room.
// Reset: rst_n clears line state, queue and output; registers return to byte mode, tab, 0 mask.
// ---------------------------------------------------------------------------
// line_byte_field_selector - cut-style byte and field selection on a byte stream
// Front end classifies bytes per line, back end emits selected bytes, buffered
// first fields and newlines through a registered output channel.
// ---------------------------------------------------------------------------
module line_byte_field_selector #(
    parameter int LINE_LEN = lbfs_pkg::LINE_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [lbfs_pkg::MASK_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        final_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        last_of_run
);
    import lbfs_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic cmd_push;
    cmd_t cmd;
    cmd_t q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_mode     <= 1'b0;
            cfg_reg.delimiter      <= TAB_BYTE;
            cfg_reg.suppress_plain <= 1'b0;
            cfg_reg.select_mask    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FIELD_MODE:  cfg_reg.field_mode     <= cfg_data[0];
                CFG_DELIMITER:   cfg_reg.delimiter      <= cfg_data[7:0];
                CFG_SUPPRESS:    cfg_reg.suppress_plain <= cfg_data[0];
                CFG_SELECT_MASK: cfg_reg.select_mask    <= cfg_data;
            endcase
        end
    end

    lbfs_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .final_req (final_req),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    lbfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    lbfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ----- test/line_byte_field_selector_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_byte_field_selector_tb - self-checking regression for the cut-style selector
// Feeds short, overlong and unterminated lines under a series of register
// settings. A scoreboard keeps its own copy of the line state, works out the
// output bytes of every accepted input transaction and checks each output
// transaction against them in order. Both sides idle in random bursts, and
// one long output hold-off makes the block back up and stall its input.
// ---------------------------------------------------------------------------
module line_byte_field_selector_tb;
    import lbfs_pkg::*;

    localparam int LINE_LEN       = 64;
    localparam int STORE_DEPTH    = 63;
    localparam int CHUNK_MAX      = 63;
    localparam int MAX_PER_BYTE   = 64;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 14;

    localparam logic [7:0] COMMA_BYTE = 8'h2C;
    localparam logic [6:0] FIELD_SAT  = 7'd127;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cut_byte_t;

    // Line-state predictor plus in-order store of expected output bytes
    class cut_scoreboard;
        bit        field_mode;
        bit [7:0]  delim;
        bit        suppress;
        bit [63:0] mask;

        bit [7:0]  first_field [STORE_DEPTH];
        bit [5:0]  chunk_cnt;
        bit [5:0]  stored_cnt;
        bit [6:0]  field_no;
        bit        delim_seen;
        bit        printed;
        bit        past_nul;

        bit [7:0]  step_bytes [$];
        cut_byte_t expected_q [$];
        int        mismatches;
        int        bytes_in;
        int        bytes_out;
        int        lines_closed;

        function new();
            field_mode   = 1'b0;
            delim        = TAB_BYTE;
            suppress     = 1'b0;
            mask         = '0;
            mismatches   = 0;
            bytes_in     = 0;
            bytes_out    = 0;
            lines_closed = 0;
            clear_line();
        endfunction

        function void clear_line();
            chunk_cnt  = '0;
            stored_cnt = '0;
            field_no   = 7'd1;
            delim_seen = 1'b0;
            printed    = 1'b0;
            past_nul   = 1'b0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [63:0] value);
            case (idx)
                CFG_FIELD_MODE:  field_mode = value[0];
                CFG_DELIMITER:   delim      = value[7:0];
                CFG_SUPPRESS:    suppress   = value[0];
                CFG_SELECT_MASK: mask       = value;
                default: ;
            endcase
        endfunction

        // Position or field k, counted from 1; nothing beyond the mask is chosen
        function bit selected(int k);
            return (k >= 1) && (k <= 64) && mask[k-1];
        endfunction

        function void put(bit [7:0] b);
            if (step_bytes.size() < MAX_PER_BYTE)
                step_bytes.push_back(b);
        endfunction

        function void drain();
            for (int i = 0; i < stored_cnt; i++)
                put(first_field[i]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One accepted input transaction: advance the line and queue its output
        function void note_input(logic [7:0] b, logic fin);
            bit        nl;
            cut_byte_t item;
            nl = (b == NL_BYTE);
            step_bytes.delete();
            bytes_in++;
            if (chunk_cnt < CHUNK_MAX)
                chunk_cnt++;

            // text up to a zero byte; newlines only ever close
            if (!nl && !past_nul)
            begin
                if (b == NUL_BYTE)
                    past_nul = 1'b1;
                else if (!field_mode)
                begin
                    if (selected(chunk_cnt))
                        put(b);
                end
                else if (b == delim)
                begin
                    if (!delim_seen)
                    begin
                        delim_seen = 1'b1;
                        if (selected(1))
                        begin
                            drain();
                            printed = 1'b1;
                        end
                        field_no = 7'd2;
                    end
                    else if (field_no < FIELD_SAT)
                        field_no++;
                    if (selected(field_no))
                    begin
                        if (printed)
                            put(delim);
                        printed = 1'b1;
                    end
                end
                else if (!delim_seen)
                begin
                    if (stored_cnt < STORE_DEPTH)
                    begin
                        first_field[stored_cnt] = b;
                        stored_cnt++;
                    end
                end
                else if (selected(field_no))
                    put(b);
            end

            // line close: newline, final byte or full chunk
            if (nl || fin || chunk_cnt >= LINE_LEN - 1)
            begin
                if (!field_mode || delim_seen)
                    put(NL_BYTE);
                else if (delim == NUL_BYTE)
                begin
                    if (selected(1))
                        drain();
                    put(NL_BYTE);
                end
                else if (!suppress)
                begin
                    drain();
                    put(NL_BYTE);
                end
                lines_closed++;
                clear_line();
            end

            foreach (step_bytes[i])
            begin
                item.data = step_bytes[i];
                item.last = (i == step_bytes.size() - 1);
                expected_q.push_back(item);
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [7:0] data, logic last);
            cut_byte_t want;
            bytes_out++;
            if (expected_q.size() == 0)
                report($sformatf("output #%0d byte %02h last %0b with nothing expected",
                                 bytes_out, data, last));
            else
            begin
                want = expected_q.pop_front();
                if (data !== want.data)
                    report($sformatf("output #%0d out_byte %02h, expected %02h",
                                     bytes_out, data, want.data));
                if (last !== want.last)
                    report($sformatf("output #%0d last_of_run %0b, expected %0b",
                                     bytes_out, last, want.last));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        final_req;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_of_run;

    bit            hold_req   = 1'b0;
    bit            calm       = 1'b0;
    int            items_sent = 0;
    int            idle_count = 0;
    int            settings_used = 0;
    cut_scoreboard sb;

    line_byte_field_selector #(
        .LINE_LEN    (LINE_LEN)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .final_req   (final_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Output checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_byte, last_of_run);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_count = 0;
            else
            begin
                idle_count++;
                if (idle_count >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                    $display("line_byte_field_selector regression: fail");
                    $finish;
                end
            end
        end
    end

    // One input transaction, with an occasional idle burst in front of it
    task automatic send_byte(input logic [7:0] value, input logic fin);
        if (!calm && !hold_req && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= value;
        final_req <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(value, fin);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Mostly short lines rich in delimiters; now and then an overlong one
    task automatic send_line();
        int         len;
        int         close_kind;
        int         roll;
        logic [7:0] value;
        logic       fin;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(40, 75);
        else
            len = $urandom_range(1, 10);
        close_kind = $urandom_range(0, 9);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            fin  = 1'b0;
            if (roll < 25)
                value = sb.delim;
            else if (roll < 27)
                value = NUL_BYTE;
            else if (roll < 29)
                value = NL_BYTE;
            else
                value = 8'($urandom_range(0, 255));
            // close kind 0 ends on a final byte, 1 leaves the line open
            if (i == len - 1 && close_kind == 0)
                fin = 1'b1;
            else if (i == len - 1 && close_kind != 1)
            begin
                value = NL_BYTE;
                fin   = ($urandom_range(0, 15) == 0);
            end
            send_byte(value, fin);
        end
    endtask

    // Stop offering and wait until the block has delivered everything
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic mode, input logic [7:0] delim,
                                 input logic sup, input logic [63:0] mask);
        cfg_idx_t    order [4];
        logic [63:0] vals  [4];
        order = '{CFG_FIELD_MODE, CFG_DELIMITER, CFG_SUPPRESS, CFG_SELECT_MASK};
        vals  = '{64'(mode), 64'(delim), 64'(sup), mask};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
            send_line();
        settle();
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FIELD_MODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        final_req <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings give bare newlines
        send_text("t\n");
        settle();

        // Byte positions 1, 3 and 64, extreme byte values, text cut at a zero byte
        apply_setting(1'b0, TAB_BYTE, 1'b0, 64'h8000_0000_0000_0005);
        send_text("AB");
        send_byte(8'hFF, 1'b0);
        send_byte(NL_BYTE, 1'b0);
        send_byte("x", 1'b0);
        send_byte(NUL_BYTE, 1'b0);
        send_text("y\n");
        settle();

        // Fields 1 and 3 joined by the delimiter
        apply_setting(1'b1, COMMA_BYTE, 1'b0, 64'h5);
        send_text("a,b,c\n");
        send_text("p,");
        settle();

        // Settings changed part way through a line; then a plain line suppressed
        apply_setting(1'b1, COMMA_BYTE, 1'b1, '1);
        send_text("q\n");
        send_text("zz\n");
        settle();

        // Newline as delimiter never splits a field
        apply_setting(1'b1, NL_BYTE, 1'b1, '1);
        send_text("r\n");
        settle();

        // Zero delimiter: whole text is field 1, closed by a final byte
        apply_setting(1'b1, NUL_BYTE, 1'b1, 64'h1);
        send_byte("s", 1'b0);
        send_byte(8'h7F, 1'b1);
        settle();

        // Random lines under a range of settings
        apply_setting(1'b0, 8'h01, 1'b0, '1);
        run_phase(PHASE_ITEMS);

        apply_setting(1'b1, 8'hFF, 1'b0, {$urandom(), $urandom()});
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);

        apply_setting(1'b1, COMMA_BYTE, 1'b1, {$urandom(), $urandom()});
        run_phase(PHASE_ITEMS);

        apply_setting(1'b0, TAB_BYTE, 1'b1, {$urandom(), $urandom()});
        run_phase(PHASE_ITEMS);

        apply_setting(1'b1, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), '0);
        run_phase(PHASE_ITEMS);

        // Last stretch runs flat out on both sides
        calm = 1'b1;
        apply_setting(1'b1, TAB_BYTE, 1'b0, {$urandom(), $urandom()});
        run_phase(PHASE_ITEMS);

        $display("summary: %0d input bytes over %0d register settings, %0d lines closed",
                 sb.bytes_in, settings_used, sb.lines_closed);
        $display("summary: %0d output bytes checked, %0d mismatches",
                 sb.bytes_out, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("line_byte_field_selector regression: pass");
        else
            $display("line_byte_field_selector regression: fail");
        $finish;
    end

endmodule
